[hw/rtl/keyed_remainder_carry_truncator_assert.svh]
// Assertion macros for the keyed remainder-carry truncator.
// Used by the RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef KEYED_REMAINDER_CARRY_TRUNCATOR_ASSERT_SVH
`define KEYED_REMAINDER_CARRY_TRUNCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KRCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("krct assertion failed");

// Next-cycle implication, disabled during reset.
`define KRCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("krct assertion failed");

`endif

[hw/rtl/krct_pkg.sv]
// Shared types and constants of the keyed remainder-carry truncator.
// No dependencies; used by krct_cell and keyed_remainder_carry_truncator.
package krct_pkg;

  localparam int ENTRIES_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int KEY_BITS_DEF  = 32;

  localparam int KEY_FIELD_W = 32;
  localparam int VALUE_W     = 48;
  localparam int RESULT_W    = 32;
  localparam int AGE_W       = 10;

  localparam logic [AGE_W-1:0] AGE_MAX       = 10'd1023;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 10'd100;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Commands broadcast to every cell.
  typedef struct packed {
    logic look;  // compare key, allocate a free entry on a miss
    logic tick;  // age every valid entry
    logic wr;    // store remainder into the selected entry
  } cell_cmd_t;

endpackage

[hw/rtl/krct_cell.sv]
// One table entry of the keyed remainder-carry truncator: key, remainder, age.
// Depends on krct_pkg; chained by keyed_remainder_carry_truncator.
module krct_cell import krct_pkg::*; #(
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cell_cmd_t                   cmd_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic                        any_hit_i,
  input  logic [AGE_W-1:0]            age_limit_i,
  input  logic signed [FRAC_BITS:0]   rem_wr_i,
  input  logic                        free_in_i,
  output logic                        free_out_o,
  input  logic [FRAC_BITS:0]          rem_in_i,
  output logic [FRAC_BITS:0]          rem_out_o,
  output logic                        hit_o,
  output logic                        sel_o
);

  logic                      valid_q, valid_d;
  logic                      sel_q, sel_d;
  logic [KEY_BITS-1:0]       key_q;
  logic signed [FRAC_BITS:0] rem_q;
  logic [AGE_W-1:0]          age_q;
  logic [AGE_W-1:0]          age_inc;
  logic                      alloc;

  assign hit_o      = valid_q && (key_q == key_i);
  assign free_out_o = free_in_i || !valid_q;
  assign alloc      = cmd_i.look && !any_hit_i && !valid_q && !free_in_i;
  // pass the remainder of a hit entry up the chain
  assign rem_out_o  = rem_in_i | (hit_o ? rem_q : '0);
  assign age_inc    = (age_q < AGE_MAX) ? age_q + AGE_W'(1) : age_q;
  assign sel_o      = sel_q;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (cmd_i.look) begin
      sel_d = hit_o || alloc;
      if (alloc) valid_d = 1'b1;
    end
    if (cmd_i.tick && valid_q && (age_inc >= age_limit_i)) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      key_q <= key_i;
      age_q <= '0;
    end else if (cmd_i.tick && valid_q) begin
      age_q <= age_inc;
    end else if (cmd_i.wr && sel_q) begin
      rem_q <= rem_wr_i;
      age_q <= '0;
    end
  end

endmodule

[hw/rtl/keyed_remainder_carry_truncator.sv]
// Keyed remainder-carry truncator: fixed-point to integer with per-key carry.
// Depends on krct_pkg, krct_cell and keyed_remainder_carry_truncator_assert.svh.
// Usage:
//   Input stream s_axis: tuser selects the word kind (0 convert, 1 tick);
//   tdata carries key in [31:0] and the signed fixed-point value in [79:32].
//   A convert word returns one result word on m_axis: tdata is the
//   truncated, saturated integer; tuser[0] flags a full table (converted
//   without carry), tuser[1] flags saturation. A tick word returns nothing.
//   Config channel cfg_*: one write sets age_limit (10 bits); write it only
//   while the block is idle. cfg_ready_o is always high.
// Sequence:
//   A convert: the cycle after accept compares the key along the cell
//   chain, then the compute step adds, truncates, writes back and registers
//   the result. A tick ages the cells in the cycle after accept. One word
//   is in flight at a time, so no new word is accepted until the last is
//   through; key compare and remainder readout ripple through cells.
// Reset: all entries are freed, age_limit returns to 100, the output is empty.
// Stall: the result register holds until m_axis_tready; a new word is still
//   accepted meanwhile, and a convert's compute step waits until it drains.
module keyed_remainder_carry_truncator import krct_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [KEY_FIELD_W+VALUE_W-1:0]  s_axis_tdata,  // key [31:0], value [79:32]
  input  logic                            s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [RESULT_W-1:0]             m_axis_tdata,  // result
  output logic [1:0]                      m_axis_tuser,  // table_full [0], saturated [1]
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [AGE_W-1:0]                cfg_data_i     // age_limit
);

  `include "keyed_remainder_carry_truncator_assert.svh"

  localparam int REM_W = FRAC_BITS + 1;
  localparam int SUM_W = VALUE_W + 1;
  localparam int QF_W  = SUM_W - FRAC_BITS;  // integer part of the sum
  localparam int QX_W  = QF_W + 33;          // room for rounding and the clamp compare
  localparam logic signed [QX_W-1:0] QMAX = QX_W'(32'sh7FFF_FFFF);
  localparam logic signed [QX_W-1:0] QMIN = QX_W'(32'sh8000_0000);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  logic [1:0] state_q, state_d;

  // Captured input word.
  logic                       op_q;
  logic [KEY_BITS-1:0]        key_q;
  logic signed [VALUE_W-1:0]  val_q;

  // Lookup outcome.
  logic                       full_q;
  logic signed [REM_W-1:0]    rem_q;

  logic [AGE_W-1:0]           age_limit_q;

  logic                       m_valid_q;
  logic [RESULT_W-1:0]        m_data_q;
  logic [1:0]                 m_user_q;

  // Cell chain.
  cell_cmd_t                  cmd;
  logic [ENTRIES:0]           free_chain;
  logic [REM_W-1:0]           rem_chain [ENTRIES+1];
  logic [ENTRIES-1:0]         hit_vec;
  logic [ENTRIES-1:0]         sel_vec;
  logic                       any_hit;

  // Truncation datapath.
  logic signed [SUM_W-1:0]    sum;
  logic [FRAC_BITS-1:0]       low;
  logic                       neg_frac;
  logic signed [QX_W-1:0]     qx;
  logic signed [REM_W-1:0]    frac;
  logic [RESULT_W-1:0]        res_sat;
  logic                       sat;
  logic                       s_acc;
  logic                       go;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  // advance the compute step only when the result register can take it
  assign go            = (state_q == ST_CALC) && (!m_valid_q || m_axis_tready);

  assign cmd.look = (state_q == ST_LOOK) && (op_q == OP_CONVERT);
  assign cmd.tick = (state_q == ST_LOOK) && (op_q == OP_TICK);
  assign cmd.wr   = go && !full_q;

  assign any_hit       = |hit_vec;
  assign free_chain[0] = 1'b0;
  assign rem_chain[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    krct_cell #(
      .KEY_BITS  (KEY_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key_q),
      .any_hit_i   (any_hit),
      .age_limit_i (age_limit_q),
      .rem_wr_i    (frac),
      .free_in_i   (free_chain[g]),
      .free_out_o  (free_chain[g+1]),
      .rem_in_i    (rem_chain[g]),
      .rem_out_o   (rem_chain[g+1]),
      .hit_o       (hit_vec[g]),
      .sel_o       (sel_vec[g])
    );
  end

  // Truncate toward zero: floor, then step up by one for a negative sum
  // with a nonzero fraction; the lost fraction is then negative.
  assign sum      = SUM_W'(val_q) + SUM_W'(rem_q);
  assign low      = sum[FRAC_BITS-1:0];
  assign neg_frac = sum[SUM_W-1] && (low != '0);
  assign qx       = QX_W'($signed(sum[SUM_W-1:FRAC_BITS]))
                  + $signed({{(QX_W-1){1'b0}}, neg_frac});
  assign frac     = $signed({neg_frac, low});

  always_comb begin
    sat     = 1'b0;
    res_sat = qx[RESULT_W-1:0];
    if (qx > QMAX) begin
      sat     = 1'b1;
      res_sat = QMAX[RESULT_W-1:0];
    end else if (qx < QMIN) begin
      sat     = 1'b1;
      res_sat = QMIN[RESULT_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        state_d = (op_q == OP_TICK) ? ST_IDLE : ST_CALC;
      end
      ST_CALC: begin
        if (go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      age_limit_q <= AGE_LIMIT_RST;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) age_limit_q <= cfg_data_i;
      if (go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the word, the lookup outcome and the result.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q  <= s_axis_tuser;
      key_q <= KEY_BITS'(s_axis_tdata[KEY_FIELD_W-1:0]);
      val_q <= $signed(s_axis_tdata[KEY_FIELD_W +: VALUE_W]);
    end
    if (cmd.look) begin
      full_q <= !any_hit && !free_chain[ENTRIES];
      rem_q  <= $signed(rem_chain[ENTRIES]);
    end
    if (go) begin
      m_data_q <= res_sat;
      m_user_q <= {sat, full_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Keys are unique in the table, so at most one cell hits.
  `KRCT_ASSERT_IMP(a_hit_unique, cmd.look, $onehot0(hit_vec))
  // A stored conversion writes exactly one cell.
  `KRCT_ASSERT_IMP(a_sel_onehot, (state_q == ST_CALC) && !full_q, $onehot(sel_vec))
  // A full table selects no cell.
  `KRCT_ASSERT_IMP(a_full_nosel, (state_q == ST_CALC) && full_q, sel_vec == '0)
  // An accepted word always goes to the lookup step next.
  `KRCT_ASSERT_NXT(a_acc_look, s_acc, state_q == ST_LOOK)

endmodule

[sim/keyed_remainder_carry_truncator_test.sv]
// Self-checking testbench for the keyed remainder-carry truncator.
// Needs krct_pkg and the keyed_remainder_carry_truncator RTL; reads no files.
// Predicts each result word from a local key table and compares field by field.
module keyed_remainder_carry_truncator_test import krct_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int SLOTS      = ENTRIES_DEF;
  localparam int POOL_SIZE  = 12;
  localparam int SETTLE     = 8;
  localparam int CYCLE_MAX  = 200000;
  localparam int REPORT_MAX = 10;

  // One input word and the result word that a convert produces.
  typedef struct packed {
    logic                     op;
    logic [KEY_FIELD_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
  } conv_word_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result;
    logic                       table_full;
    logic                       saturated;
  } conv_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [KEY_FIELD_W+VALUE_W-1:0] s_axis_tdata = '0;  // key [31:0], value [79:32]
  logic                           s_axis_tuser = OP_CONVERT;  // op
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [RESULT_W-1:0]            m_axis_tdata;  // result
  logic [1:0]                     m_axis_tuser;  // table_full [0], saturated [1]
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [AGE_W-1:0]               cfg_data_i = '0;  // age_limit

  keyed_remainder_carry_truncator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the block's key table and its age_limit register.
  logic                     shadow_valid [SLOTS];
  logic [KEY_FIELD_W-1:0]   shadow_key   [SLOTS];
  logic signed [FRAC:0]     shadow_rem   [SLOTS];
  logic [AGE_W-1:0]         shadow_age   [SLOTS];
  logic [AGE_W-1:0]         shadow_age_limit;

  conv_result_t             pending_results[$];
  logic [KEY_FIELD_W-1:0]   key_pool[POOL_SIZE];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  longint unsigned cycle_count = 0;

  // Age every live entry; free those that reach the limit.
  function automatic void age_entries();
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i]) begin
        if (shadow_age[i] != AGE_MAX) shadow_age[i] = shadow_age[i] + 1'b1;
        if (shadow_age[i] >= shadow_age_limit) shadow_valid[i] = 1'b0;
      end
    end
  endfunction

  // Look up or allocate the key, add its carried fraction, truncate toward
  // zero, store the lost fraction and clamp to the 32-bit range.
  function automatic conv_result_t convert_predict(logic [KEY_FIELD_W-1:0] key,
                                                   logic signed [VALUE_W-1:0] value);
    conv_result_t res;
    int           slot;
    longint       sum;
    longint       carry;
    longint       quot;
    longint       frac;
    slot  = -1;
    carry = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    end
    if (slot < 0) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !shadow_valid[i]) begin
          slot            = i;
          shadow_valid[i] = 1'b1;
          shadow_key[i]   = key;
          shadow_rem[i]   = '0;
          shadow_age[i]   = '0;
        end
      end
    end
    res.table_full = (slot < 0);
    if (slot >= 0) carry = shadow_rem[slot];
    sum = value;
    sum = sum + carry;
    if (sum >= 0) begin
      quot = sum >>> FRAC;
    end else begin
      quot = -((-sum) >>> FRAC);
    end
    frac = sum - quot * (longint'(1) << FRAC);
    if (slot >= 0) begin
      shadow_rem[slot] = frac[FRAC:0];
      shadow_age[slot] = '0;
    end
    res.saturated = 1'b1;
    if (quot > 64'sd2147483647) begin
      quot = 64'sd2147483647;
    end else if (quot < -64'sd2147483648) begin
      quot = -64'sd2147483648;
    end else begin
      res.saturated = 1'b0;
    end
    res.result = quot[RESULT_W-1:0];
    return res;
  endfunction

  // Offer one word after a random gap; predict it once the block takes it.
  task automatic send_word(conv_word_t w);
    conv_result_t exp_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.value, w.key};
    s_axis_tuser  <= w.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (w.op == OP_TICK) begin
      age_entries();
    end else begin
      exp_res = convert_predict(w.key, w.value);
      pending_results.insert(pending_results.size(), exp_res);
    end
  endtask

  task automatic send_convert(logic [KEY_FIELD_W-1:0] key, logic signed [VALUE_W-1:0] value);
    send_word('{op: OP_CONVERT, key: key, value: value});
  endtask

  task automatic send_tick();
    send_word('{op: OP_TICK, key: $urandom, value: VALUE_W'({$urandom, $urandom})});
  endtask

  // Drop tvalid and hold until every predicted word has been delivered.
  task automatic hold_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write age_limit only once the block is idle: a trailing tick leaves no
  // result behind, so let it pass with margin.
  task automatic write_age_limit(logic [AGE_W-1:0] limit);
    hold_for_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i      <= 1'b0;
    shadow_age_limit = limit;
  endtask

  // Carry, rounding toward zero, saturation and a full table.
  task automatic test_directed_carry();
    send_convert(32'h0000_0000, 48'sh0);
    send_convert(32'hFFFF_FFFF, 48'sh0000_0000_8000);    // half carried
    send_convert(32'hFFFF_FFFF, 48'sh0000_0000_8000);    // halves add to one
    send_convert(32'h0000_0001, -48'sh0000_0000_C000);   // negative truncates to 0
    send_convert(32'h0000_0001, -48'sh0000_0000_8000);   // carried -0.75 makes -1.25
    send_convert(32'h0000_0002, 48'sh7FFF_FFFF_FFFF);    // largest value, fraction kept
    send_convert(32'h0000_0002, 48'sh7FFF_FFFF_FFFF);    // carry pushes past the top
    send_convert(32'h0000_0003, 48'sh8000_0000_0000);    // most negative value
    send_convert(32'h0000_0003, -48'sh1);
    send_convert(32'h0000_0004, 48'sh0000_0001_0000);
    send_convert(32'h0000_0005, -48'sh0000_0001_0000);
    send_convert(32'h0000_0006, 48'sh0000_0000_FFFF);    // table now full
    send_convert(32'h0000_0007, 48'sh0000_0001_8000);    // no entry free
    send_convert(32'h0000_0007, 48'sh0000_0001_8000);    // still no carry
  endtask

  // Expiry at small limits, including a limit of zero.
  task automatic test_directed_aging();
    write_age_limit(10'd2);
    send_tick();
    send_convert(32'h0000_0001, 48'sh0);   // age reset, survives the next tick
    send_tick();                           // everything else expires here
    send_tick();                           // key 1 expires too
    send_convert(32'h0000_0007, 48'sh0000_0000_4000);
    write_age_limit(10'd0);
    send_tick();                           // frees every live entry
    send_convert(32'hFFFF_FFFF, 48'sh0000_0000_8000);
    send_convert(32'h0000_0002, 48'sh0000_0000_0001);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [63:0] r;
    int unsigned pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 5) return {{(VALUE_W-19){r[18]}}, r[18:0]};       // a few units
    if (pick < 7) return r[VALUE_W-1:0];                          // anywhere
    if (pick == 7) return 48'sh7FFF_FFFF_FFFF - r[17:0];          // near the top
    if (pick == 8) return 48'sh8000_0000_0000 + r[17:0];          // near the bottom
    return {{(VALUE_W-17){r[16]}}, r[16:0]};                      // under one unit
  endfunction

  // Mostly converts on a pool larger than the table, so entries get reused,
  // evicted by age and refused when the table is full; some stray keys.
  task automatic test_random_traffic(int count, logic [AGE_W-1:0] limit,
                                     int unsigned send_pct, int unsigned recv_pct);
    logic [KEY_FIELD_W-1:0] key;
    write_age_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) hold_for_results();
      if ($urandom_range(0, 99) < 12) begin
        send_tick();
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
          key = $urandom;
        end
        send_convert(key, random_value());
      end
    end
  endtask

  // Receiver: stall at random per the current idle rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each delivered word against the oldest prediction.
  always @(posedge clk_i) begin
    conv_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result word: data %h user %b", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata !== exp_res.result || m_axis_tuser[0] !== exp_res.table_full ||
            m_axis_tuser[1] !== exp_res.saturated) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("result mismatch: expected %h full %b sat %b, got %h full %b sat %b",
                     exp_res.result, exp_res.table_full, exp_res.saturated,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("** keyed_remainder_carry_truncator: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_rem[i]   = '0;
      shadow_age[i]   = '0;
    end
    shadow_age_limit = AGE_LIMIT_RST;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 22;
    recv_idle_pct = 67;
    test_directed_carry();
    test_directed_aging();

    test_random_traffic(100, 10'd1, 22, 67);
    test_random_traffic(100, 10'd3, 22, 67);
    test_random_traffic(100, 10'd1023, 67, 22);
    test_random_traffic(100, 10'd5, 67, 22);
    test_random_traffic(100, AGE_LIMIT_RST, 0, 0);
    test_random_traffic(100, 10'd2, 0, 0);

    hold_for_results();
    repeat (2 * SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** keyed_remainder_carry_truncator: PASSED **");
    end else begin
      $display("** keyed_remainder_carry_truncator: FAILED **");
    end
    $finish;
  end

endmodule
